// ===== rtl/imm_pkg.sv =====
package imm_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 3;
    localparam int VALUE_W    = 16;
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int PROD_W     = 35;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_B = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_size;
        logic [CFG_W-1:0] cols_b;
    } t_cfg;

    typedef struct packed {
        t_cmd                cmd;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [VALUE_W-1:0]  value;
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic [PROD_W-1:0] product;
        logic              last;
    } t_res;

endpackage

// ===== rtl/imm_if.sv =====
interface imm_in_if;
    logic                             valid;
    logic                             ready;
    logic [imm_pkg::CMD_W-1:0]        command;
    logic [imm_pkg::IDX_W-1:0]        row;
    logic [imm_pkg::IDX_W-1:0]        col;
    logic signed [imm_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input command, input row, input col, input value,
                    output ready);
endinterface

interface imm_out_if;
    logic                              valid;
    logic                              ready;
    logic [imm_pkg::IDX_W-1:0]         out_row;
    logic [imm_pkg::IDX_W-1:0]         out_col;
    logic signed [imm_pkg::PROD_W-1:0] product;
    logic                              last;

    modport source (output valid, output out_row, output out_col, output product,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input product,
                    input last, output ready);
endinterface

// ===== rtl/imm_ram.sv =====
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/imm_queue.sv =====
module imm_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    output logic o_valid,
    output T     o_data,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/imm_front.sv =====
module imm_front #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    imm_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output imm_pkg::t_op  o_op
);

    imm_pkg::t_cmd w_cmd;
    logic          w_in_range;
    logic          w_keep;

    assign w_cmd      = imm_pkg::t_cmd'(i_in.command);
    assign w_in_range = (32'(i_in.row) < MAX_DIM) && (32'(i_in.col) < MAX_DIM);

    always_comb begin
        case (w_cmd)
            imm_pkg::CMD_WRITE_A: w_keep = w_in_range;
            imm_pkg::CMD_WRITE_B: w_keep = w_in_range;
            imm_pkg::CMD_COMPUTE: w_keep = 1'b1;
            default:              w_keep = 1'b0;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && w_keep;

    assign o_op.cmd   = w_cmd;
    assign o_op.row   = i_in.row;
    assign o_op.col   = i_in.col;
    assign o_op.value = i_in.value;

endmodule

// ===== rtl/imm_back.sv =====
module imm_back #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  imm_pkg::t_cfg i_cfg,
    input  logic          i_op_valid,
    input  imm_pkg::t_op  i_op,
    output logic          o_op_ready,
    output logic          o_res_push,
    output imm_pkg::t_res o_res,
    input  logic          i_res_pop
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int PW    = 2 * ELEM_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    function automatic logic [CW-1:0] clamp_dim(input logic [imm_pkg::CFG_W-1:0] d);
        return (32'(d) > MAX_DIM) ? CW'(MAX_DIM) : CW'(d);
    endfunction

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_nr, r_nk, r_nc;
    logic                      r_zero;
    logic [CW-1:0]             r_i, r_j, r_k;
    logic [imm_pkg::PEND_W-1:0] r_pending;
    logic [DEPTH-1:0]          r_vld_a, r_vld_b;

    logic                      r_s1_valid, r_s1_first, r_s1_lastk, r_s1_last, r_s1_zero;
    logic                      r_s1_va, r_s1_vb;
    logic [CW-1:0]             r_s1_i, r_s1_j;
    logic                      r_s2_valid, r_s2_first, r_s2_lastk, r_s2_last;
    logic [CW-1:0]             r_s2_i, r_s2_j;
    logic signed [PW-1:0]      r_s2_prod;
    logic [imm_pkg::PROD_W-1:0] r_acc, n_acc;

    logic                      w_idle, w_start, w_issue, w_first;
    logic                      w_k_end, w_j_end, w_i_end;
    logic                      w_we_a, w_we_b;
    logic [AW-1:0]             w_waddr, w_addr_a, w_addr_b;
    logic [ELEM_WIDTH-1:0]     w_wdata;
    logic signed [ELEM_WIDTH-1:0] w_rd_a, w_rd_b;
    logic signed [PW-1:0]      w_mul;
    logic [CW-1:0]             w_nr, w_nk, w_nc;

    assign w_idle     = (r_state == ST_IDLE);
    assign o_op_ready = w_idle;

    always_comb begin
        w_we_a  = 1'b0;
        w_we_b  = 1'b0;
        w_start = 1'b0;
        case (i_op.cmd)
            imm_pkg::CMD_WRITE_A: w_we_a  = w_idle && i_op_valid;
            imm_pkg::CMD_WRITE_B: w_we_b  = w_idle && i_op_valid;
            imm_pkg::CMD_COMPUTE: w_start = w_idle && i_op_valid;
            default: ;
        endcase
    end

    assign w_waddr  = AW'(32'(i_op.row) * MAX_DIM + 32'(i_op.col));
    assign w_wdata  = ELEM_WIDTH'(signed'(i_op.value));
    assign w_addr_a = AW'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_addr_b = AW'(32'(r_k) * MAX_DIM + 32'(r_j));

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_a),
        .o_rdata (w_rd_a)
    );

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_b),
        .o_rdata (w_rd_b)
    );

    assign w_nr = clamp_dim(i_cfg.rows_a);
    assign w_nk = clamp_dim(i_cfg.inner_size);
    assign w_nc = clamp_dim(i_cfg.cols_b);

    assign w_first = (r_k == '0);
    assign w_issue = (r_state == ST_RUN)
                     && (!w_first || r_pending < imm_pkg::PEND_W'(imm_pkg::OUT_DEPTH));
    assign w_k_end = (r_k + 1'b1 == r_nk);
    assign w_j_end = (r_j + 1'b1 == r_nc);
    assign w_i_end = (r_i + 1'b1 == r_nr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start && w_nr != '0 && w_nc != '0) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_issue && w_k_end && w_j_end && w_i_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_pending <= '0;
            r_vld_a   <= '0;
            r_vld_b   <= '0;
        end else begin
            r_state <= n_state;
            if (w_we_a) begin
                r_vld_a[w_waddr] <= 1'b1;
            end
            if (w_we_b) begin
                r_vld_b[w_waddr] <= 1'b1;
            end
            if (w_start) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else if (w_issue) begin
                if (!w_k_end) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_k <= '0;
                    if (!w_j_end) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end
                end
            end
            case ({w_issue && w_first, i_res_pop})
                2'b10: r_pending <= r_pending + 1'b1;
                2'b01: r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_nr   <= w_nr;
            r_nk   <= (w_nk == '0) ? CW'(1) : w_nk;
            r_nc   <= w_nc;
            r_zero <= (w_nk == '0);
        end
    end

    // read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign w_mul = w_rd_a * w_rd_b;

    always_ff @(posedge i_clk) begin
        r_s1_first <= w_first;
        r_s1_lastk <= w_k_end;
        r_s1_last  <= w_k_end && w_j_end && w_i_end;
        r_s1_zero  <= r_zero;
        r_s1_va    <= r_vld_a[w_addr_a];
        r_s1_vb    <= r_vld_b[w_addr_b];
        r_s1_i     <= r_i;
        r_s1_j     <= r_j;

        r_s2_first <= r_s1_first;
        r_s2_lastk <= r_s1_lastk;
        r_s2_last  <= r_s1_last;
        r_s2_i     <= r_s1_i;
        r_s2_j     <= r_s1_j;
        r_s2_prod  <= (r_s1_va && r_s1_vb && !r_s1_zero) ? w_mul : '0;

        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    assign n_acc = r_s2_first ? imm_pkg::PROD_W'(r_s2_prod)
                              : r_acc + imm_pkg::PROD_W'(r_s2_prod);

    assign o_res_push    = r_s2_valid && r_s2_lastk;
    assign o_res.out_row = imm_pkg::IDX_W'(r_s2_i);
    assign o_res.out_col = imm_pkg::IDX_W'(r_s2_j);
    assign o_res.product = n_acc;
    assign o_res.last    = r_s2_last;

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= imm_pkg::PEND_W'(imm_pkg::OUT_DEPTH))
        else $error("result reservations exceed queue depth");

    a_pop_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_pop |-> (r_pending != '0))
        else $error("result taken without a reservation");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_k < r_nk))
        else $error("inner index out of range");

endmodule

// ===== rtl/integer_matrix_multiply_top.sv =====
// Signed integer matrix multiplier. Element writes (command 0 for A, command 1
// for B) are taken one per cycle while the command queue has room and land in
// two element stores that read as zero until written; writes outside MAX_DIM
// and command 3 are dropped. Command 2 emits C = A*B in row-major order over
// rows_a x inner_size x cols_b (each clamped to MAX_DIM), with last set on the
// final word. A single multiply-accumulate unit reads one A and one B element
// per cycle while a result slot can be reserved in the output queue, and each
// word of C sums max(inner_size, 1) products: the stores are read, the product
// is registered and then accumulated before the word enters the output queue.
// Commands wait in a four-deep queue while a product is being computed. Sizes
// are written by the user only while the block is idle, which is not enforced.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [imm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [imm_pkg::CFG_W-1:0]        i_cfg_data,
    imm_in_if.sink                           i_in,
    imm_out_if.source                        o_out
);

    imm_pkg::t_cfg r_cfg;
    imm_pkg::t_op  w_front_op, w_op;
    imm_pkg::t_res w_res, w_out_res;
    logic          w_front_push, w_cmd_full, w_op_valid, w_op_ready;
    logic          w_res_push, w_res_full, w_res_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_a     <= imm_pkg::CFG_RESET;
            r_cfg.inner_size <= imm_pkg::CFG_RESET;
            r_cfg.cols_b     <= imm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                imm_pkg::CFG_ROWS_A: r_cfg.rows_a     <= i_cfg_data;
                imm_pkg::CFG_INNER:  r_cfg.inner_size <= i_cfg_data;
                imm_pkg::CFG_COLS_B: r_cfg.cols_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_in   (i_in),
        .i_full (w_cmd_full),
        .o_push (w_front_push),
        .o_op   (w_front_op)
    );

    imm_queue #(.T(imm_pkg::t_op), .DEPTH(imm_pkg::CMD_DEPTH)) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_op),
        .o_full  (w_cmd_full),
        .o_valid (w_op_valid),
        .o_data  (w_op),
        .i_pop   (w_op_ready)
    );

    imm_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_ready (w_op_ready),
        .o_res_push (w_res_push),
        .o_res      (w_res),
        .i_res_pop  (w_res_pop)
    );

    imm_queue #(.T(imm_pkg::t_res), .DEPTH(imm_pkg::OUT_DEPTH)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_valid (o_out.valid),
        .o_data  (w_out_res),
        .i_pop   (w_res_pop)
    );

    assign w_res_pop     = o_out.valid && o_out.ready;
    assign o_out.out_row = w_out_res.out_row;
    assign o_out.out_col = w_out_res.out_col;
    assign o_out.product = w_out_res.product;
    assign o_out.last    = w_out_res.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (!w_res_full || w_res_pop))
        else $error("result word pushed into a full queue");

endmodule

// ===== test/integer_matrix_multiply_top_test.sv =====
module integer_matrix_multiply_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM           = imm_pkg::MAX_DIM_DEF;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [imm_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [imm_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [imm_pkg::CFG_W-1:0]      cfg_data;

    imm_in_if  in_word ();
    imm_out_if out_word ();

    integer_matrix_multiply_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_in       (in_word),
        .o_out      (out_word)
    );

    // mirror of the block: element stores, sizes and the product words still owed
    logic signed [imm_pkg::VALUE_W-1:0] a_mirror [0:DIM*DIM-1];
    logic signed [imm_pkg::VALUE_W-1:0] b_mirror [0:DIM*DIM-1];
    logic [imm_pkg::CFG_W-1:0]          rows_cfg;
    logic [imm_pkg::CFG_W-1:0]          inner_cfg;
    logic [imm_pkg::CFG_W-1:0]          cols_cfg;
    imm_pkg::t_res                      pending_words [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int clamp_dim(logic [imm_pkg::CFG_W-1:0] s);
        return (s > DIM) ? DIM : int'(s);
    endfunction

    task automatic mirror_command(imm_pkg::t_cmd cmd, logic [imm_pkg::IDX_W-1:0] r,
                                  logic [imm_pkg::IDX_W-1:0] c,
                                  logic signed [imm_pkg::VALUE_W-1:0] v);
        int   nr;
        int   nk;
        int   nc;
        longint acc;
        imm_pkg::t_res word;
        nr = clamp_dim(rows_cfg);
        nk = clamp_dim(inner_cfg);
        nc = clamp_dim(cols_cfg);
        case (cmd)
            imm_pkg::CMD_WRITE_A: begin
                if (r < DIM && c < DIM) a_mirror[r*DIM + c] = v;
            end
            imm_pkg::CMD_WRITE_B: begin
                if (r < DIM && c < DIM) b_mirror[r*DIM + c] = v;
            end
            imm_pkg::CMD_COMPUTE: begin
                for (int i = 0; i < nr; i++) begin
                    for (int j = 0; j < nc; j++) begin
                        acc = 0;
                        for (int k = 0; k < nk; k++) begin
                            acc += longint'(a_mirror[i*DIM + k]) * longint'(b_mirror[k*DIM + j]);
                        end
                        word.out_row = imm_pkg::IDX_W'(i);
                        word.out_col = imm_pkg::IDX_W'(j);
                        word.product = acc[imm_pkg::PROD_W-1:0];
                        word.last    = (i == nr - 1) && (j == nc - 1);
                        pending_words.push_back(word);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge clk) begin
        if (rst_n && in_word.valid && in_word.ready) begin
            mirror_command(imm_pkg::t_cmd'(in_word.command), in_word.row, in_word.col,
                           in_word.value);
        end
    end

    task automatic flag_mismatch(string field, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk) begin
        imm_pkg::t_res want;
        if (rst_n && out_word.valid && out_word.ready) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected word: row %0d col %0d product %0d last %0d",
                             out_word.out_row, out_word.out_col, out_word.product,
                             out_word.last);
                end
            end else begin
                want = pending_words.pop_front();
                if (out_word.out_row !== want.out_row)
                    flag_mismatch("out_row", want.out_row, out_word.out_row);
                if (out_word.out_col !== want.out_col)
                    flag_mismatch("out_col", want.out_col, out_word.out_col);
                if (out_word.product !== $signed(want.product))
                    flag_mismatch("product", $signed(want.product), out_word.product);
                if (out_word.last !== want.last)
                    flag_mismatch("last", want.last, out_word.last);
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_word.ready <= 1'b0;
        end else begin
            out_word.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("integer_matrix_multiply_top verification failed");
            $finish;
        end
    end

    task automatic send_word(imm_pkg::t_cmd cmd, logic [imm_pkg::IDX_W-1:0] r,
                             logic [imm_pkg::IDX_W-1:0] c,
                             logic [imm_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_word.valid <= 1'b0;
            @(posedge clk);
        end
        in_word.valid   <= 1'b1;
        in_word.command <= cmd;
        in_word.row     <= r;
        in_word.col     <= c;
        in_word.value   <= v;
        do @(posedge clk); while (!(in_word.valid && in_word.ready));
    endtask

    task automatic wait_for_products();
        in_word.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sizes(logic [imm_pkg::CFG_W-1:0] r, logic [imm_pkg::CFG_W-1:0] k,
                             logic [imm_pkg::CFG_W-1:0] c, bit touch_spare);
        rows_cfg  = r;
        inner_cfg = k;
        cols_cfg  = c;
        cfg_we   <= 1'b1;
        cfg_addr <= imm_pkg::CFG_ROWS_A;
        cfg_data <= r;
        @(posedge clk);
        cfg_addr <= imm_pkg::CFG_INNER;
        cfg_data <= k;
        @(posedge clk);
        cfg_addr <= imm_pkg::CFG_COLS_B;
        cfg_data <= c;
        @(posedge clk);
        if (touch_spare) begin
            cfg_addr <= CFG_SPARE;
            cfg_data <= 4'hF;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [imm_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return imm_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [imm_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return 4'd0;
            1:       return 4'd8;
            2:       return imm_pkg::CFG_W'($urandom_range(9, 15));
            default: return imm_pkg::CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [imm_pkg::IDX_W-1:0] pick_index(int n);
        if (n == 0 || $urandom_range(3) == 0) return imm_pkg::IDX_W'($urandom_range(7));
        return imm_pkg::IDX_W'($urandom_range(n - 1));
    endfunction

    // stores read as zero and sizes are 8x8x8 out of reset
    task automatic test_reset_contents();
        send_word(imm_pkg::CMD_NONE, 3'd7, 3'd7, 16'hFFFF);
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_for_products();
    endtask

    // largest positive and negative sums; inner size above the store clamps
    task automatic test_extreme_sums();
        set_sizes(4'd1, 4'd9, 4'd2, 1'b0);
        for (int k = 0; k < DIM; k++) begin
            send_word(imm_pkg::CMD_WRITE_A, 3'd0, imm_pkg::IDX_W'(k), 16'h8000);
            send_word(imm_pkg::CMD_WRITE_B, imm_pkg::IDX_W'(k), 3'd0, 16'h8000);
            send_word(imm_pkg::CMD_WRITE_B, imm_pkg::IDX_W'(k), 3'd1, 16'h7FFF);
        end
        send_word(imm_pkg::CMD_COMPUTE, 3'd5, 3'd2, 16'h1234);
        wait_for_products();
    endtask

    // zero rows, zero inner size, zero columns, oversized registers
    task automatic test_degenerate_sizes();
        set_sizes(4'd0, 4'd3, 4'd15, 1'b1);
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_for_products();
        set_sizes(4'd15, 4'd0, 4'd1, 1'b0);
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_for_products();
        set_sizes(4'd2, 4'd2, 4'd0, 1'b0);
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_for_products();
    endtask

    task automatic test_random_traffic(int n_items);
        int   count;
        int   len;
        imm_pkg::t_cmd cmd;
        for (int blk = 0; blk < 3; blk++) begin
            set_sizes(pick_size(), pick_size(), pick_size(), 1'b0);
            count = 0;
            while (count < n_items / 3) begin
                if ($urandom_range(9) < 7) begin
                    len = $urandom_range(1, 12);
                    repeat (len) begin
                        if ($urandom_range(1) == 0) begin
                            send_word(imm_pkg::CMD_WRITE_A, pick_index(clamp_dim(rows_cfg)),
                                      pick_index(clamp_dim(inner_cfg)), rand_value());
                        end else begin
                            send_word(imm_pkg::CMD_WRITE_B, pick_index(clamp_dim(inner_cfg)),
                                      pick_index(clamp_dim(cols_cfg)), rand_value());
                        end
                    end
                    send_word(imm_pkg::CMD_COMPUTE, imm_pkg::IDX_W'($urandom),
                              imm_pkg::IDX_W'($urandom), imm_pkg::VALUE_W'($urandom));
                    count += len + 1;
                end else begin
                    cmd = imm_pkg::t_cmd'($urandom_range(3));
                    send_word(cmd, imm_pkg::IDX_W'($urandom), imm_pkg::IDX_W'($urandom),
                              rand_value());
                    if (cmd != imm_pkg::CMD_NONE) count++;
                end
            end
            wait_for_products();
        end
    endtask

    // receiver holds off while commands keep coming, so the block backs up
    task automatic test_output_backpressure();
        set_sizes(4'd8, 4'd1, 4'd8, 1'b0);
        hold_request = 300;
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        for (int k = 0; k < 6; k++) begin
            send_word(imm_pkg::CMD_WRITE_A, imm_pkg::IDX_W'($urandom), 3'd0, rand_value());
            send_word(imm_pkg::CMD_WRITE_B, 3'd0, imm_pkg::IDX_W'($urandom), rand_value());
        end
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_word(imm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_for_products();
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = imm_pkg::CFG_ROWS_A;
        cfg_data        = '0;
        in_word.valid   = 1'b0;
        in_word.command = imm_pkg::CMD_NONE;
        in_word.row     = '0;
        in_word.col     = '0;
        in_word.value   = '0;
        out_word.ready  = 1'b0;
        rows_cfg        = imm_pkg::CFG_RESET;
        inner_cfg       = imm_pkg::CFG_RESET;
        cols_cfg        = imm_pkg::CFG_RESET;
        mismatch_count  = 0;
        hold_request    = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 22;
        recv_idle_pct   = 83;
        for (int i = 0; i < DIM*DIM; i++) begin
            a_mirror[i] = '0;
            b_mirror[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_extreme_sums();
        test_degenerate_sizes();
        test_random_traffic(66);

        send_idle_pct = 83;
        recv_idle_pct = 22;
        test_random_traffic(66);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(66);

        wait_for_products();
        if (mismatch_count == 0) begin
            $display("integer_matrix_multiply_top verification clean");
        end else begin
            $display("integer_matrix_multiply_top verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/imm_pkg.sv
rtl/imm_if.sv
rtl/imm_ram.sv
rtl/imm_queue.sv
rtl/imm_front.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply_top.sv
test/integer_matrix_multiply_top_test.sv
